>>> rtl/pbcf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbcf_pkg
// Shared types and constants of the parallel byte capture FIFO.
// ----------------------------------------------------------------------------
package pbcf_pkg;

  // Operation carried in the slave-side tuser
  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_READ   = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  // Command kinds passed from the front end to the back end
  typedef enum logic [1:0] {
    CMD_STATUS = 2'd0,
    CMD_EDGE   = 2'd1,
    CMD_READ   = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_kind_e;

  // Back-end sequencer states
  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_READ = 1'b1
  } back_state_e;

  // Configuration register indexes
  localparam logic [1:0] CFG_PIN_MAP  = 2'd0;
  localparam logic [1:0] CFG_CAPACITY = 2'd1;
  localparam logic [1:0] CFG_ENABLE   = 2'd2;

  // Pin mapping constants
  localparam logic [7:0] PIN_UNUSED = 8'd255;
  localparam logic [7:0] LOW_PINS   = 8'd32;
  localparam logic [7:0] TOTAL_PINS = 8'd40;

  // Reset values of the configuration registers
  localparam logic [63:0] PIN_MAP_RESET  = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [10:0] CAPACITY_RESET = 11'd1024;

  // Field widths
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned AVAIL_W = 11;
  localparam int unsigned RCNT_W  = 7;

  // Command queue depth
  localparam int unsigned QDEPTH = 2;

  typedef struct packed {
    cmd_kind_e         kind;
    logic [7:0]        data;
    logic [RCNT_W-1:0] count;
  } cmd_t;

  typedef struct packed {
    logic [7:0]         read_byte;
    logic               byte_valid;
    logic               last;
    logic [AVAIL_W-1:0] available;
    logic               buffer_is_full;
    logic [CNT_W-1:0]   captured_total;
    logic [CNT_W-1:0]   edges_total;
    logic [CNT_W-1:0]   overflow_total;
  } res_t;

endpackage

>>> rtl/parallel_byte_capture_fifo_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// parallel_byte_capture_fifo_top
// Captures mapped GPIO bytes on pixel clock rising edges into a ring buffer
// and reads them out with fill level and statistics.
//
//   channel  | direction | handshake               | payload
//   ---------+-----------+-------------------------+--------------------------
//   s_axis   | in        | s_axis_tvalid/tready    | tdata sample/read, tuser op
//   m_axis   | out       | m_axis_tvalid/tready    | tdata result, tuser, tlast
//   cfg      | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// Sample, clear and idle items sustain one per cycle, and a read item gives one
// result per cycle, up to MAX_READ, while neither side stalls, paced by the
// single ring memory read port. An accepted item passes through the command
// queue, then the result register. Reset clears pointers and counters at once;
// ring contents are undefined until written. Either side may stall: the
// two-entry command queue and the result register hold items meanwhile.
// ----------------------------------------------------------------------------
module parallel_byte_capture_fifo_top #(
  parameter int unsigned DEPTH    = 1024,
  parameter int unsigned MAX_READ = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: pclk_level[0], gpio_low[32:1], gpio_high[40:33], read_count[47:41]
  input  logic [47:0]  s_axis_tdata,
  // tuser: op[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: read_byte[7:0], available[18:8], buffer_is_full[19],
  //        captured_total[51:20], edges_total[83:52], overflow_total[115:84],
  //        zero[119:116]
  output logic [119:0] m_axis_tdata,
  // tuser: byte_valid
  output logic         m_axis_tuser,
  output logic         m_axis_tlast,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [63:0]  cfg_data_i
);
  import pbcf_pkg::*;

  logic [63:0] pin_map_q, pin_map_d;
  logic [10:0] capacity_q, capacity_d;
  logic        enable_q, enable_d;
  logic        cfg_write;
  logic        cap_wr;

  logic        fq_valid, fq_ready;
  cmd_t        fq_cmd;
  logic        qb_valid, qb_ready;
  cmd_t        qb_cmd;
  res_t        res;

  // Configuration registers
  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;
  assign cap_wr      = cfg_write && (cfg_index_i == CFG_CAPACITY);

  always_comb begin
    pin_map_d  = pin_map_q;
    capacity_d = capacity_q;
    enable_d   = enable_q;
    if (cfg_write) begin
      case (cfg_index_i)
        CFG_PIN_MAP:  pin_map_d  = cfg_data_i;
        CFG_CAPACITY: capacity_d = cfg_data_i[10:0];
        CFG_ENABLE:   enable_d   = cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pin_map_q  <= PIN_MAP_RESET;
      capacity_q <= CAPACITY_RESET;
      enable_q   <= 1'b0;
    end else begin
      pin_map_q  <= pin_map_d;
      capacity_q <= capacity_d;
      enable_q   <= enable_d;
    end
  end

  pbcf_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (s_axis_tvalid),
    .ready_o          (s_axis_tready),
    .op_i             (s_axis_tuser),
    .pclk_level_i     (s_axis_tdata[0]),
    .gpio_low_i       (s_axis_tdata[32:1]),
    .gpio_high_i      (s_axis_tdata[40:33]),
    .read_count_i     (s_axis_tdata[47:41]),
    .pin_map_i        (pin_map_q),
    .capture_enable_i (enable_q),
    .cmd_valid_o      (fq_valid),
    .cmd_ready_i      (fq_ready),
    .cmd_o            (fq_cmd)
  );

  pbcf_cmd_q u_cmd_q (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_cmd_i   (fq_cmd),
    .pop_valid_o  (qb_valid),
    .pop_ready_i  (qb_ready),
    .pop_cmd_o    (qb_cmd)
  );

  pbcf_back #(
    .DEPTH    (DEPTH),
    .MAX_READ (MAX_READ)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .capacity_i  (capacity_q),
    .cap_wr_i    (cap_wr),
    .cmd_valid_i (qb_valid),
    .cmd_ready_o (qb_ready),
    .cmd_i       (qb_cmd),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  // Pack the result
  assign m_axis_tdata = {4'b0000, res.overflow_total, res.edges_total,
                         res.captured_total, res.buffer_is_full,
                         res.available, res.read_byte};
  assign m_axis_tuser = res.byte_valid;
  assign m_axis_tlast = res.last;

  // A result without a byte always closes its item
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
    else $error("status result without tlast");

  // A result without a byte carries a zero byte
  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[7:0] == 8'd0)
    else $error("status result with nonzero byte");

  // A full buffer always reports a nonzero fill level
  a_full_avail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[19] |-> m_axis_tdata[18:8] != 11'd0)
    else $error("full flag with empty fill level");

  // A popped byte leaves the buffer not full
  a_pop_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> !m_axis_tdata[19])
    else $error("full flag after a pop");

endmodule

>>> rtl/pbcf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbcf_front
// Accepts input items, detects pixel clock edges, gathers the mapped pins
// into a byte and issues one command per item to the command queue.
// ----------------------------------------------------------------------------
module pbcf_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  logic [1:0]          op_i,
  input  logic                pclk_level_i,
  input  logic [31:0]         gpio_low_i,
  input  logic [7:0]          gpio_high_i,
  input  logic [6:0]          read_count_i,
  input  logic [63:0]         pin_map_i,
  input  logic                capture_enable_i,
  output logic                cmd_valid_o,
  input  logic                cmd_ready_i,
  output pbcf_pkg::cmd_t      cmd_o
);
  import pbcf_pkg::*;

  logic       prev_level_q, prev_level_d;
  logic [7:0] gathered;
  logic       accept;
  op_e        op;

  assign op          = op_e'(op_i);
  assign ready_o     = cmd_ready_i;
  assign cmd_valid_o = valid_i;
  assign accept      = valid_i && cmd_ready_i;

  // Gather the eight mapped pins; unused or out-of-range indexes give 0
  always_comb begin
    logic [7:0] pin;
    gathered = '0;
    for (int k = 0; k < 8; k++) begin
      pin = pin_map_i[8*k +: 8];
      if (pin < LOW_PINS) begin
        gathered[k] = gpio_low_i[pin[4:0]];
      end else if (pin < TOTAL_PINS) begin
        gathered[k] = gpio_high_i[pin[2:0]];
      end
    end
  end

  // Classify the item
  always_comb begin
    cmd_o.data  = gathered;
    cmd_o.count = read_count_i;
    case (op)
      OP_SAMPLE: begin
        if (capture_enable_i && pclk_level_i && !prev_level_q) begin
          cmd_o.kind = CMD_EDGE;
        end else begin
          cmd_o.kind = CMD_STATUS;
        end
      end
      OP_READ:  cmd_o.kind = CMD_READ;
      OP_CLEAR: cmd_o.kind = CMD_CLEAR;
      default:  cmd_o.kind = CMD_STATUS;
    endcase
  end

  // Track the last pixel clock level seen by a sample item
  always_comb begin
    prev_level_d = prev_level_q;
    if (accept && op == OP_SAMPLE) begin
      prev_level_d = pclk_level_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_level_q <= 1'b0;
    end else begin
      prev_level_q <= prev_level_d;
    end
  end

endmodule

>>> rtl/pbcf_cmd_q.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbcf_cmd_q
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module pbcf_cmd_q (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  pbcf_pkg::cmd_t push_cmd_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output pbcf_pkg::cmd_t pop_cmd_o
);
  import pbcf_pkg::*;

  localparam int unsigned PTR_W = $clog2(QDEPTH);
  localparam int unsigned CNT_QW = $clog2(QDEPTH + 1);

  cmd_t              slots_q [QDEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_QW-1:0] cnt_q, cnt_d;
  logic              push, pop;

  assign push_ready_o = (cnt_q != CNT_QW'(QDEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_cmd_o    = slots_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CNT_QW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CNT_QW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Hold payload
  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

>>> rtl/pbcf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbcf_back
// Ring buffer, fill tracking and statistics counters; carries out commands
// and drives the result register.
// ----------------------------------------------------------------------------
module pbcf_back #(
  parameter int unsigned DEPTH    = 1024,
  parameter int unsigned MAX_READ = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [10:0]    capacity_i,
  input  logic           cap_wr_i,
  input  logic           cmd_valid_i,
  output logic           cmd_ready_o,
  input  pbcf_pkg::cmd_t cmd_i,
  output logic           res_valid_o,
  input  logic           res_ready_i,
  output pbcf_pkg::res_t res_o
);
  import pbcf_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [7:0]        ring_mem [DEPTH];
  logic [7:0]        rd_data_q;

  back_state_e       state_q, state_d;
  logic [PW-1:0]     wp_q, wp_d;
  logic [PW-1:0]     rp_q, rp_d;
  logic [CW-1:0]     fill_q, fill_d;
  logic [RCNT_W-1:0] rem_q, rem_d;
  logic [CNT_W-1:0]  capt_q, capt_d;
  logic [CNT_W-1:0]  edge_q, edge_d;
  logic [CNT_W-1:0]  ovf_q, ovf_d;
  logic              out_valid_q, out_valid_d;
  res_t              res_q, res_d;

  logic [CW-1:0]     cap_used;
  logic              full_now;
  logic              slot_free;
  logic              mem_we;
  logic              load;
  logic [7:0]        out_byte;
  logic              out_bvalid;
  logic              out_last;
  logic [RCNT_W-1:0] want;

  function automatic logic [PW-1:0] next_pos(input logic [PW-1:0] p,
                                             input logic [CW-1:0] c);
    logic [CW-1:0] n;
    n = CW'(p) + CW'(1);
    return (n >= c) ? '0 : PW'(n);
  endfunction

  // Clamp the configured capacity to 1..DEPTH
  always_comb begin
    if (32'(capacity_i) > DEPTH) begin
      cap_used = CW'(DEPTH);
    end else if (capacity_i == '0) begin
      cap_used = CW'(1);
    end else begin
      cap_used = CW'(capacity_i);
    end
  end

  assign full_now  = (fill_q == cap_used);
  assign slot_free = !out_valid_q || res_ready_i;
  assign want      = (cmd_i.count > RCNT_W'(MAX_READ)) ? RCNT_W'(MAX_READ) : cmd_i.count;

  // Sequencer: next state, pointer and counter updates, result formation
  always_comb begin
    state_d     = state_q;
    wp_d        = wp_q;
    rp_d        = rp_q;
    fill_d      = fill_q;
    rem_d       = rem_q;
    capt_d      = capt_q;
    edge_d      = edge_q;
    ovf_d       = ovf_q;
    mem_we      = 1'b0;
    cmd_ready_o = 1'b0;
    load        = 1'b0;
    out_byte    = '0;
    out_bvalid  = 1'b0;
    out_last    = 1'b1;
    out_valid_d = out_valid_q && !res_ready_i;

    case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i && slot_free) begin
          cmd_ready_o = 1'b1;
          load        = 1'b1;
          case (cmd_i.kind)
            CMD_EDGE: begin
              if (full_now) begin
                ovf_d = ovf_q + CNT_W'(1);
              end else begin
                mem_we = 1'b1;
                wp_d   = next_pos(wp_q, cap_used);
                fill_d = fill_q + CW'(1);
                capt_d = capt_q + CNT_W'(1);
              end
              edge_d = edge_q + CNT_W'(1);
            end
            CMD_CLEAR: begin
              capt_d = '0;
              edge_d = '0;
              ovf_d  = '0;
            end
            CMD_READ: begin
              if (want != '0 && fill_q != '0) begin
                out_byte   = rd_data_q;
                out_bvalid = 1'b1;
                rp_d       = next_pos(rp_q, cap_used);
                fill_d     = fill_q - CW'(1);
                rem_d      = want - RCNT_W'(1);
                out_last   = (want == RCNT_W'(1)) || (fill_d == '0);
                if (!out_last) begin
                  state_d = BK_READ;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      BK_READ: begin
        if (slot_free) begin
          load       = 1'b1;
          out_byte   = rd_data_q;
          out_bvalid = 1'b1;
          rp_d       = next_pos(rp_q, cap_used);
          fill_d     = fill_q - CW'(1);
          rem_d      = rem_q - RCNT_W'(1);
          out_last   = (rem_q == RCNT_W'(1)) || (fill_d == '0);
          if (out_last) begin
            state_d = BK_IDLE;
          end
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase

    // A capacity write empties the ring
    if (cap_wr_i) begin
      wp_d   = '0;
      rp_d   = '0;
      fill_d = '0;
    end

    // Form the result from the updated state
    res_d = res_q;
    if (load) begin
      out_valid_d          = 1'b1;
      res_d.read_byte      = out_byte;
      res_d.byte_valid     = out_bvalid;
      res_d.last           = out_last;
      res_d.available      = AVAIL_W'(fill_d);
      res_d.buffer_is_full = (fill_d == cap_used);
      res_d.captured_total = capt_d;
      res_d.edges_total    = edge_d;
      res_d.overflow_total = ovf_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      wp_q        <= '0;
      rp_q        <= '0;
      fill_q      <= '0;
      rem_q       <= '0;
      capt_q      <= '0;
      edge_q      <= '0;
      ovf_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      rp_q        <= rp_d;
      fill_q      <= fill_d;
      rem_q       <= rem_d;
      capt_q      <= capt_d;
      edge_q      <= edge_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  // Ring memory; the read port always presents the entry at the next read
  // position, with a bypass when that entry is written in the same cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_mem[wp_q] <= cmd_i.data;
    end
    if (mem_we && wp_q == rp_d) begin
      rd_data_q <= cmd_i.data;
    end else begin
      rd_data_q <= ring_mem[rp_d];
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule
